// File: sv/cyb_pkg.sv
// Shared types and constants for the cropped YUV to BGR converter.
// Register map codes, register reset values and coefficient thousandths.
// No dependencies.
package cyb_pkg;

	// Register map: index of each register, taken from paddr[4:2]
	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_FRAME_WIDTH  = 3'd0;
	localparam reg_idx_t REG_FRAME_HEIGHT = 3'd1;
	localparam reg_idx_t REG_SIDE_CROP    = 3'd2;
	localparam reg_idx_t REG_TOP_CROP     = 3'd3;
	localparam reg_idx_t REG_BOTTOM_CROP  = 3'd4;

	// Register widths
	localparam int DIM_W    = 12;
	localparam int SIDE_W   = 10;
	localparam int VCROP_W  = 11;
	localparam int SAMPLE_W = 8;

	// Register reset values
	localparam logic [DIM_W-1:0]   FRAME_WIDTH_RST  = 12'd1164;
	localparam logic [DIM_W-1:0]   FRAME_HEIGHT_RST = 12'd874;
	localparam logic [SIDE_W-1:0]  SIDE_CROP_RST    = 10'd175;
	localparam logic [VCROP_W-1:0] TOP_CROP_RST     = 11'd0;
	localparam logic [VCROP_W-1:0] BOTTOM_CROP_RST  = 11'd209;

	// BT.601 limited-range coefficients in thousandths
	localparam longint MILLI_Y  = 1164;
	localparam longint MILLI_RV = 1596;
	localparam longint MILLI_GV = 813;
	localparam longint MILLI_GU = 391;
	localparam longint MILLI_BU = 2018;

	// Offsets removed from the samples
	localparam logic signed [SAMPLE_W:0] LUMA_OFFSET   = 9'sd16;
	localparam logic signed [SAMPLE_W:0] CHROMA_OFFSET = 9'sd128;

	// One pixel as it sits in the input stage
	typedef struct packed {
		logic [SAMPLE_W-1:0] chroma_red;
		logic [SAMPLE_W-1:0] chroma_blue;
		logic [SAMPLE_W-1:0] luma;
	} pixel_t;

endpackage

// File: sv/cropped_yuv_to_bgr_converter.sv
// Cropped limited-range BT.601 YUV to BGR converter, top level.
// Holds the crop registers, raster counters, input stage and result register.
// Depends on cyb_pkg.
//
// Channel   Dir  Handshake              Payload
// s_*       in   s_tvalid / s_tready    s_tdata: luma, chroma_blue, chroma_red
// m_*       out  m_tvalid / m_tready    m_tdata: blue, green, red; m_tlast: window_last
// APB       in   psel, penable, pready  5 registers at byte address 4*i
//
// One pixel is accepted every cycle while s_tready is high; a converted word passes
// through the input stage register and then the result register.
// Pixels outside the crop window only advance the counters and leave no word.
// A stalled output holds the result register; the input stage still takes one
// more pixel, and s_tready falls only when both registers are full.
// Reset clears counters, stage valid flags and loads the register defaults.
module cropped_yuv_to_bgr_converter
	import cyb_pkg::*;
#(
	parameter int MAX_DIM        = 2048,
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [7:0] luma, [15:8] chroma_blue, [23:16] chroma_red
	// Output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] blue, [15:8] green, [23:16] red
	output logic        m_tlast,   // window_last
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CNT_W = $clog2(MAX_DIM);
	localparam int SUM_W = ((CNT_W > DIM_W) ? CNT_W : DIM_W) + 2;
	localparam int ACC_W = COEF_FRAC_BITS + 14;
	localparam int WHOLE_W = ACC_W - COEF_FRAC_BITS;

	// Coefficients rounded to COEF_FRAC_BITS fraction bits
	localparam longint K_Y_L  = ((MILLI_Y  << COEF_FRAC_BITS) + 500) / 1000;
	localparam longint K_RV_L = ((MILLI_RV << COEF_FRAC_BITS) + 500) / 1000;
	localparam longint K_GV_L = ((MILLI_GV << COEF_FRAC_BITS) + 500) / 1000;
	localparam longint K_GU_L = ((MILLI_GU << COEF_FRAC_BITS) + 500) / 1000;
	localparam longint K_BU_L = ((MILLI_BU << COEF_FRAC_BITS) + 500) / 1000;
	localparam logic signed [ACC_W-1:0] K_Y  = ACC_W'(K_Y_L);
	localparam logic signed [ACC_W-1:0] K_RV = ACC_W'(K_RV_L);
	localparam logic signed [ACC_W-1:0] K_GV = ACC_W'(K_GV_L);
	localparam logic signed [ACC_W-1:0] K_GU = ACC_W'(K_GU_L);
	localparam logic signed [ACC_W-1:0] K_BU = ACC_W'(K_BU_L);
	localparam logic [SUM_W-1:0] MAX_DIM_X = SUM_W'(MAX_DIM);

	// Configuration registers
	logic [DIM_W-1:0]   frame_width_q;
	logic [DIM_W-1:0]   frame_height_q;
	logic [SIDE_W-1:0]  side_crop_q;
	logic [VCROP_W-1:0] top_crop_q;
	logic [VCROP_W-1:0] bottom_crop_q;

	// Raster counters
	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;

	// Input stage and result register
	logic           valid_s1;
	pixel_t         pix_s1;
	logic           last_s1;
	logic           out_valid_q;
	logic [23:0]    out_data_q;
	logic           out_last_q;

	logic           s_fire;
	logic           out_adv;
	logic           cfg_write;
	reg_idx_t       reg_idx;
	logic [SUM_W-1:0] col_x, row_x, fw_x, fh_x, side_x, top_x, bottom_x;
	logic [SUM_W-1:0] next_col, next_row;
	logic           in_window, last_px, col_wrap, row_wrap;
	logic signed [SAMPLE_W:0] d_y, d_u, d_v;
	logic signed [ACC_W-1:0]  y_prod, rv_prod, gv_prod, gu_prod, bu_prod;
	logic signed [ACC_W-1:0]  blue_sum, green_sum, red_sum;
	logic [SAMPLE_W-1:0]      blue_px, green_px, red_px;

	// Truncate the fraction and clamp to one byte
	function automatic logic [SAMPLE_W-1:0] to_byte(input logic signed [ACC_W-1:0] s);
		logic [WHOLE_W-1:0] whole;
		logic [SAMPLE_W-1:0] res;
		whole = s[ACC_W-1:COEF_FRAC_BITS];
		if (s[ACC_W-1]) begin
			res = '0;
		end else if (|whole[WHOLE_W-1:SAMPLE_W]) begin
			res = '1;
		end else begin
			res = whole[SAMPLE_W-1:0];
		end
		return res;
	endfunction

	// Configuration port
	assign pready    = 1'b1;
	assign reg_idx   = paddr[4:2];
	assign cfg_write = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			side_crop_q    <= SIDE_CROP_RST;
			top_crop_q     <= TOP_CROP_RST;
			bottom_crop_q  <= BOTTOM_CROP_RST;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[DIM_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[DIM_W-1:0];
				REG_SIDE_CROP:    side_crop_q    <= pwdata[SIDE_W-1:0];
				REG_TOP_CROP:     top_crop_q     <= pwdata[VCROP_W-1:0];
				REG_BOTTOM_CROP:  bottom_crop_q  <= pwdata[VCROP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FRAME_WIDTH:  prdata = 32'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = 32'(frame_height_q);
			REG_SIDE_CROP:    prdata = 32'(side_crop_q);
			REG_TOP_CROP:     prdata = 32'(top_crop_q);
			REG_BOTTOM_CROP:  prdata = 32'(bottom_crop_q);
			default:          prdata = '0;
		endcase
	end

	// Handshake: the input stage moves on whenever the result register frees up
	assign out_adv  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || out_adv;
	assign s_fire   = s_tvalid && s_tready;

	// Window test and counter step, all without wrap-around
	assign col_x    = SUM_W'(col_q);
	assign row_x    = SUM_W'(row_q);
	assign fw_x     = SUM_W'(frame_width_q);
	assign fh_x     = SUM_W'(frame_height_q);
	assign side_x   = SUM_W'(side_crop_q);
	assign top_x    = SUM_W'(top_crop_q);
	assign bottom_x = SUM_W'(bottom_crop_q);

	assign in_window = (col_x >= side_x) && (col_x + side_x < fw_x) &&
	                   (row_x >= top_x) && (row_x + bottom_x < fh_x);
	assign last_px   = in_window && (col_x + side_x + 1'b1 == fw_x) &&
	                   (row_x + bottom_x + 1'b1 == fh_x);

	assign next_col = col_x + 1'b1;
	assign next_row = row_x + 1'b1;
	assign col_wrap = (next_col >= fw_x) || (next_col >= MAX_DIM_X);
	assign row_wrap = (next_row >= fh_x) || (next_row >= MAX_DIM_X);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (s_fire) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : next_row[CNT_W-1:0];
			end else begin
				col_q <= next_col[CNT_W-1:0];
			end
		end
	end

	// Input stage: only pixels inside the window are kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_fire && in_window;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire && in_window) begin
			pix_s1  <= s_tdata;
			last_s1 <= last_px;
		end
	end

	// Colour conversion: one constant product per term, then sum and clamp
	assign d_y = $signed({1'b0, pix_s1.luma}) - LUMA_OFFSET;
	assign d_u = $signed({1'b0, pix_s1.chroma_blue}) - CHROMA_OFFSET;
	assign d_v = $signed({1'b0, pix_s1.chroma_red}) - CHROMA_OFFSET;

	assign y_prod  = K_Y  * ACC_W'(d_y);
	assign rv_prod = K_RV * ACC_W'(d_v);
	assign gv_prod = K_GV * ACC_W'(d_v);
	assign gu_prod = K_GU * ACC_W'(d_u);
	assign bu_prod = K_BU * ACC_W'(d_u);

	assign blue_sum  = y_prod + bu_prod;
	assign green_sum = y_prod - gv_prod - gu_prod;
	assign red_sum   = y_prod + rv_prod;

	assign blue_px  = to_byte(blue_sum);
	assign green_px = to_byte(green_sum);
	assign red_px   = to_byte(red_sum);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s1) begin
			out_data_q <= {red_px, green_px, blue_px};
			out_last_q <= last_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	// A pixel waiting in the input stage stays put while the result register is stuck
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_adv |=> valid_s1 && $stable(pix_s1) && $stable(last_s1))
		else $error("input stage lost or changed a waiting pixel");

	// A pixel outside the window never reaches the input stage
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && !in_window |=> !valid_s1)
		else $error("pixel outside the crop window was kept");

	// Without a wrap the column counter steps by one
	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && !col_wrap |=> col_q == $past(col_q) + 1'b1)
		else $error("column counter did not advance by one");
`endif

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the cropped YUV to BGR converter.
// Streams pixels through crop settings from reset values to extremes and checks
// every word against a local predictor. Depends on cyb_pkg and the converter.
module testbench;
	import cyb_pkg::*;

	localparam int HALF_PERIOD   = 6;
	localparam int RESET_CYCLES  = 11;
	localparam int MAX_GAP       = 17;
	localparam int DRAIN_CYCLES  = 4;
	localparam int STALL_LIMIT   = 2000;
	localparam int RANDOM_PIXELS = 1120;
	localparam int MAX_DIM       = 2048;
	localparam int FRAC          = 16;

	// Q16 coefficients, rounded from thousandths
	localparam longint K_Y  = ((MILLI_Y  << FRAC) + 500) / 1000;
	localparam longint K_RV = ((MILLI_RV << FRAC) + 500) / 1000;
	localparam longint K_GV = ((MILLI_GV << FRAC) + 500) / 1000;
	localparam longint K_GU = ((MILLI_GU << FRAC) + 500) / 1000;
	localparam longint K_BU = ((MILLI_BU << FRAC) + 500) / 1000;

	// Addresses past the last register, which the block must ignore
	localparam reg_idx_t REG_SPARE_FIRST = REG_BOTTOM_CROP + 3'd1;
	localparam reg_idx_t REG_SPARE_LAST  = '1;

	// Rails and primaries, packed as chroma_red, chroma_blue, luma
	localparam pixel_t CORNER_PIXELS [17] = '{
		24'h000000, 24'h000000, 24'hFFFFFF, 24'h808010, 24'h8080EB, 24'h8080FF,
		24'h808000, 24'hFF00FF, 24'h00FFFF, 24'h00FF00, 24'hFF0000, 24'hF06E51,
		24'h10F029, 24'h22B691, 24'h0080FF, 24'hFF8000, 24'h80FF10
	};

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       window_last;
	} bgr_word_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;   // [7:0] luma, [15:8] chroma_blue, [23:16] chroma_red
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;         // [7:0] blue, [15:8] green, [23:16] red
	logic        m_tlast;         // window_last
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [4:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	// Predictor copy of the registers and raster position
	logic [DIM_W-1:0]   cfg_width  = FRAME_WIDTH_RST;
	logic [DIM_W-1:0]   cfg_height = FRAME_HEIGHT_RST;
	logic [SIDE_W-1:0]  cfg_side   = SIDE_CROP_RST;
	logic [VCROP_W-1:0] cfg_top    = TOP_CROP_RST;
	logic [VCROP_W-1:0] cfg_bottom = BOTTOM_CROP_RST;
	int unsigned        pix_col    = 0;
	int unsigned        pix_row    = 0;

	bgr_word_t pending_bgr [$];
	bgr_word_t exp_word;
	bit        quiet       = 1'b0;
	int        stall_left  = 0;
	int        idle_cycles = 0;
	int        errors      = 0;
	int        n_sent      = 0;
	int        n_checked   = 0;
	int        n_writes    = 0;

	cropped_yuv_to_bgr_converter u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic int draw_gap();
		return quiet ? 0 : int'($urandom_range(0, MAX_GAP));
	endfunction

	function automatic logic [7:0] clamp_byte(longint sum);
		longint whole;
		if (sum < 0)
			return 8'd0;
		whole = sum >>> FRAC;
		return (whole > 255) ? 8'd255 : whole[7:0];
	endfunction

	// Advance the raster position and queue the word that a window pixel gives.
	function automatic void convert_pixel(pixel_t px);
		int unsigned col;
		int unsigned row;
		int unsigned nxt;
		bit          in_window;
		bit          window_end;
		longint      d;
		longint      du;
		longint      dv;
		longint      ys;
		bgr_word_t   w;
		col = pix_col;
		row = pix_row;
		in_window = col >= cfg_side && col + cfg_side < cfg_width &&
			row >= cfg_top && row + cfg_bottom < cfg_height;
		window_end = in_window && col + cfg_side + 1 == cfg_width &&
			row + cfg_bottom + 1 == cfg_height;
		nxt = col + 1;
		if (nxt >= cfg_width || nxt >= MAX_DIM) begin
			pix_col = 0;
			nxt = row + 1;
			pix_row = (nxt >= cfg_height || nxt >= MAX_DIM) ? 0 : nxt;
		end else begin
			pix_col = nxt;
		end
		if (!in_window)
			return;
		d  = longint'(px.luma) - longint'(LUMA_OFFSET);
		du = longint'(px.chroma_blue) - longint'(CHROMA_OFFSET);
		dv = longint'(px.chroma_red) - longint'(CHROMA_OFFSET);
		ys = K_Y * d;
		w.blue        = clamp_byte(ys + K_BU * du);
		w.green       = clamp_byte(ys - K_GV * dv - K_GU * du);
		w.red         = clamp_byte(ys + K_RV * dv);
		w.window_last = window_end;
		pending_bgr.push_back(w);
	endfunction

	function automatic logic [31:0] reg_shadow(reg_idx_t idx);
		case (idx)
			REG_FRAME_WIDTH:  return 32'(cfg_width);
			REG_FRAME_HEIGHT: return 32'(cfg_height);
			REG_SIDE_CROP:    return 32'(cfg_side);
			REG_TOP_CROP:     return 32'(cfg_top);
			REG_BOTTOM_CROP:  return 32'(cfg_bottom);
			default:          return 32'd0;
		endcase
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t px;
		px = pixel_t'(24'($urandom));
		// Push a sample onto a rail now and then so that clamping is exercised.
		if ($urandom_range(0, 4) == 0)
			px.luma = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		if ($urandom_range(0, 4) == 0)
			px.chroma_blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		if ($urandom_range(0, 4) == 0)
			px.chroma_red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return px;
	endfunction

	task automatic check_field(string what, int expected, int actual);
		if (expected != actual) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, expected,
				actual);
		end
	endtask

	// Send one pixel after a random gap and hold it until the block takes it.
	task automatic send_pixel(pixel_t px);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		do @(posedge clk); while (!s_tready);
		convert_pixel(px);
		n_sent++;
	endtask

	task automatic send_pixels(int count);
		repeat (count) send_pixel(random_pixel());
	endtask

	// Stop sending and wait until every queued word has come out.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_bgr.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Read a register over the configuration port and compare with the shadow copy.
	task automatic check_reg(reg_idx_t idx);
		logic [31:0] readback;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		check_field($sformatf("register %0d readback", idx), int'(reg_shadow(idx)),
			int'(readback));
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_FRAME_WIDTH:  cfg_width  = value[DIM_W-1:0];
			REG_FRAME_HEIGHT: cfg_height = value[DIM_W-1:0];
			REG_SIDE_CROP:    cfg_side   = value[SIDE_W-1:0];
			REG_TOP_CROP:     cfg_top    = value[VCROP_W-1:0];
			REG_BOTTOM_CROP:  cfg_bottom = value[VCROP_W-1:0];
			default:          ;
		endcase
		n_writes++;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (idx <= REG_BOTTOM_CROP)
			check_reg(idx);
	endtask

	task automatic set_window(int unsigned fw, int unsigned fh, int unsigned sc,
			int unsigned tc, int unsigned bc);
		drain();
		write_reg(REG_FRAME_WIDTH, fw);
		write_reg(REG_FRAME_HEIGHT, fh);
		write_reg(REG_SIDE_CROP, sc);
		write_reg(REG_TOP_CROP, tc);
		write_reg(REG_BOTTOM_CROP, bc);
	endtask

	// Reset defaults: read every register, then run into the left edge of the window.
	task automatic test_reset_window();
		for (int i = REG_FRAME_WIDTH; i <= REG_BOTTOM_CROP; i++)
			check_reg(reg_idx_t'(i));
		send_pixels(int'(SIDE_CROP_RST) + 16);
	endtask

	// Rails and primaries through a small uncropped frame.
	task automatic test_colour_extremes();
		set_window(4, 4, 0, 0, 0);
		for (int i = 0; i < $size(CORNER_PIXELS); i++)
			send_pixel(CORNER_PIXELS[i]);
	endtask

	// Crops on every side, single-column and single-row windows, empty windows.
	task automatic test_crop_windows();
		set_window(10, 8, 2, 1, 2);
		send_pixels(160);
		set_window(9, 7, 4, 0, 0);
		send_pixels(70);
		set_window(10, 6, 5, 0, 0);
		send_pixels(30);
		set_window(6, 9, 0, 4, 5);
		send_pixels(30);
		set_window(6, 9, 0, 3, 5);
		send_pixels(60);
	endtask

	// Zero and one sized frames, crop registers at their maxima, unmapped addresses.
	task automatic test_degenerate_sizes();
		set_window(0, 0, 0, 0, 0);
		send_pixels(12);
		set_window(1, 1, 0, 0, 0);
		send_pixels(12);
		set_window(1, 2, 0, 0, 1);
		send_pixels(12);
		set_window(2, 2, 1, 0, 0);
		send_pixels(12);
		set_window(3, 4095, 1023, 2047, 2047);
		send_pixels(12);
		set_window(2, 3, 0, 1, 0);
		write_reg(REG_SPARE_FIRST, '1);
		write_reg(REG_SPARE_LAST, '1);
		send_pixels(12);
	endtask

	// Random small frames and crops, with no-gap phases and full pauses mixed in.
	task automatic test_random_frames();
		int budget;
		int count;
		int unsigned fw;
		int unsigned fh;
		budget = RANDOM_PIXELS;
		while (budget > 0) begin
			if ($urandom_range(0, 7) == 0) begin
				fw = $urandom_range(2, 300);
				fh = $urandom_range(2, 20);
			end else begin
				fw = $urandom_range(2, 16);
				fh = $urandom_range(2, 10);
			end
			set_window(fw, fh, $urandom_range(0, fw / 2), $urandom_range(0, fh / 2),
				$urandom_range(0, fh / 2));
			if ($urandom_range(0, 5) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_FIRST : REG_SPARE_LAST, $urandom);
			quiet = ($urandom_range(0, 3) == 0);
			count = fw * fh * $urandom_range(1, 3);
			if (count > 250)
				count = $urandom_range(60, 250);
			if (count > budget)
				count = budget;
			for (int i = 0; i < count; i++) begin
				send_pixel(random_pixel());
				if ($urandom_range(0, 63) == 0)
					drain();
			end
			budget -= count;
		end
		quiet = 1'b0;
	endtask

	// Output side: compare each word with the oldest prediction and stall at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_bgr.size() == 0) begin
					errors++;
					$display("%0t: unexpected word, expected none, actual %h last %b", $time,
						m_tdata, m_tlast);
				end else begin
					exp_word = pending_bgr.pop_front();
					check_field("blue", exp_word.blue, m_tdata[7:0]);
					check_field("green", exp_word.green, m_tdata[15:8]);
					check_field("red", exp_word.red, m_tdata[23:16]);
					check_field("window_last", exp_word.window_last, m_tlast);
					n_checked++;
				end
				stall_left = draw_gap();
			end else if (stall_left > 0) begin
				stall_left--;
			end
			m_tready <= (stall_left == 0);
		end
	end

	// Watchdog on cycles in which no word and no register access completes.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_window();
		test_colour_extremes();
		test_crop_windows();
		test_degenerate_sizes();
		test_random_frames();
		drain();
		$display("Sent %0d pixels, checked %0d converted words, made %0d register writes.",
			n_sent, n_checked, n_writes);
		$display("Crops ranged from reset defaults through empty windows to maximum sizes.");
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: cropped_yuv_to_bgr_converter.f
sv/cyb_pkg.sv
sv/cropped_yuv_to_bgr_converter.sv
tb/sv/testbench.sv
